### hw/rtl/ddmc_pkg.sv
package ddmc_pkg;

    // Field widths of the pixel and result streams
    localparam int COL_W      = 10;
    localparam int PIX_W      = 8;
    localparam int DISP_W     = 12;
    localparam int COST_W     = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Color channels: three are stored, CHANNELS of them take part in the cost
    localparam int CH_MAX   = 3;
    localparam int CHANNELS = 3;
    localparam int NUM_CH   = (CHANNELS < CH_MAX) ? CHANNELS : CH_MAX;

    // Disparity fixed point
    localparam int FRAC_BITS = 4;

    // Position word: column scaled by 2^FRAC_BITS plus a signed disparity
    localparam int POS_W = COL_W + FRAC_BITS + 3;

    // Interpolated color in 2^-FRAC_BITS units, and its signed working width
    localparam int IP_W = PIX_W + FRAC_BITS;
    localparam int IS_W = PIX_W + FRAC_BITS + 2;

    // Reset value of the width register
    localparam int IMAGE_WIDTH_RESET = 1024;

    // Request codes
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_NEGATIVE = 1'b1;

    // One pixel: [0] red, [1] green, [2] blue
    typedef logic [CH_MAX-1:0][PIX_W-1:0] pix_t;

    // Stage enables handed to a cost lane
    typedef struct packed {
        logic load_interp;
        logic load_cost;
    } lane_ctrl_t;

endpackage

### hw/rtl/ddmc_cost_lane.sv
module ddmc_cost_lane
    import ddmc_pkg::*;
(
    input  logic                 clk,
    input  lane_ctrl_t           ctrl,
    input  pix_t                 lo_pix,
    input  pix_t                 hi_pix,
    input  logic [FRAC_BITS-1:0] frac,
    input  pix_t                 ref_pix,
    output logic [COST_W-1:0]    cost
);

    logic [CH_MAX-1:0][IP_W-1:0] interp_next;
    logic [CH_MAX-1:0][IP_W-1:0] interp_reg;
    pix_t                        ref_reg;
    logic [COST_W-1:0]           cost_next;
    logic [COST_W-1:0]           cost_reg;

    // Interpolate each channel as lo * 2^F + (hi - lo) * frac
    always_comb
    begin
        logic signed [PIX_W:0]  diff;
        logic signed [IS_W-1:0] prod;
        logic signed [IS_W-1:0] base;
        logic signed [IS_W-1:0] sum;
        logic [PIX_W-1:0]       hi_eff;
        for (int c = 0; c < CH_MAX; c++)
        begin
            // drop the upper neighbor on an integer position
            hi_eff = (frac != '0) ? hi_pix[c] : '0;
            diff   = $signed({1'b0, hi_eff}) - $signed({1'b0, lo_pix[c]});
            prod   = IS_W'(diff) * $signed({1'b0, frac});
            base   = $signed({2'b00, lo_pix[c], {FRAC_BITS{1'b0}}});
            sum    = base + prod;
            interp_next[c] = sum[IP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_interp)
        begin
            interp_reg <= interp_next;
            ref_reg    <= ref_pix;
        end
    end

    // Sum absolute differences over the active channels
    always_comb
    begin
        logic [IP_W-1:0] scaled;
        logic [IP_W-1:0] absd;
        cost_next = '0;
        for (int c = 0; c < CH_MAX; c++)
        begin
            scaled = {ref_reg[c], {FRAC_BITS{1'b0}}};
            absd   = (scaled >= interp_reg[c]) ? (scaled - interp_reg[c])
                                               : (interp_reg[c] - scaled);
            if (c < NUM_CH)
            begin
                cost_next = cost_next + COST_W'(absd);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_cost)
        begin
            cost_reg <= cost_next;
        end
    end

    assign cost = cost_reg;

endmodule

### hw/rtl/dual_disparity_matching_cost.sv
// An accepted evaluate request passes stages 1, 2 and 3 and the output register.
// Throughput: one request per cycle, stores and evaluates alike, unless out_ready
// stalls; even/odd template banks serve both neighbors of both hypotheses per read.
// Reset: clears all stage valid bits and the output valid; width returns to 1024
// (capped at MAX_WIDTH), shift_negative to 1. The template memory is not cleared.
module dual_disparity_matching_cost
    import ddmc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [COL_W-1:0]             column,
    input  logic [PIX_W-1:0]             red,
    input  logic [PIX_W-1:0]             green,
    input  logic [PIX_W-1:0]             blue,
    input  logic signed [DISP_W-1:0]     disp_forward,
    input  logic signed [DISP_W-1:0]     disp_backward,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [COL_W-1:0]             out_column,
    output logic [COST_W-1:0]            match_cost,
    output logic                         backward_chosen,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int BANK_DEPTH = MAX_WIDTH / 2 + 1;
    localparam int BA_W       = $clog2(BANK_DEPTH);
    localparam int FLW        = POS_W - FRAC_BITS;
    localparam int CW         = (FLW > AW) ? FLW : AW;
    localparam int RESET_W    = (MAX_WIDTH < IMAGE_WIDTH_RESET) ? MAX_WIDTH
                                                                : IMAGE_WIDTH_RESET;
    localparam logic [AW-1:0] RESET_LAST = AW'(RESET_W - 1);

    typedef struct packed {
        logic [AW-1:0]        fl;
        logic [FRAC_BITS-1:0] fr;
    } loc_t;

    // Clamp column -/+ disparity to the row and split floor and fraction
    function automatic loc_t locate(
        input logic [COL_W-1:0]         col,
        input logic signed [DISP_W-1:0] disp,
        input logic                     neg,
        input logic [AW-1:0]            last
    );
        logic signed [POS_W-1:0] cpos;
        logic signed [POS_W-1:0] dext;
        logic signed [POS_W-1:0] p;
        logic [FLW-1:0]          fl_raw;
        logic [FRAC_BITS-1:0]    fr_raw;
        loc_t                    r;
        cpos   = $signed(POS_W'({col, {FRAC_BITS{1'b0}}}));
        dext   = POS_W'(disp);
        p      = neg ? (cpos - dext) : (cpos + dext);
        fl_raw = p[POS_W-1:FRAC_BITS];
        fr_raw = p[FRAC_BITS-1:0];
        if (p < 0)
        begin
            r.fl = '0;
            r.fr = '0;
        end
        else if ((CW'(fl_raw) > CW'(last)) || ((CW'(fl_raw) == CW'(last)) && (fr_raw != '0)))
        begin
            r.fl = last;
            r.fr = '0;
        end
        else
        begin
            r.fl = AW'(fl_raw);
            r.fr = fr_raw;
        end
        return r;
    endfunction

    // Last usable column for a written width
    function automatic logic [AW-1:0] last_column(input logic [CFG_DATA_W-1:0] w);
        logic [CFG_DATA_W-1:0] w_m1;
        logic [AW-1:0]         r;
        w_m1 = w - 1'b1;
        if (w == '0)
        begin
            r = '0;
        end
        else if (32'(w) > MAX_WIDTH)
        begin
            r = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            r = AW'(w_m1);
        end
        return r;
    endfunction

    // Configuration registers
    logic [AW-1:0] last_col_reg;
    logic          shift_negative_reg;

    // Stage 1: memory read data and request fields
    logic                 v1_reg;
    logic                 v1_next;
    logic [COL_W-1:0]     col1_reg;
    pix_t                 ref1_reg;
    logic [FRAC_BITS-1:0] fr_f1_reg;
    logic [FRAC_BITS-1:0] fr_b1_reg;
    logic                 odd_f1_reg;
    logic                 odd_b1_reg;
    pix_t                 even_f_rd_reg;
    pix_t                 odd_f_rd_reg;
    pix_t                 even_b_rd_reg;
    pix_t                 odd_b_rd_reg;

    // Stages 2 and 3 and the output register
    logic             v2_reg;
    logic             v3_reg;
    logic [COL_W-1:0] col2_reg;
    logic [COL_W-1:0] col3_reg;
    logic             o_valid_reg;
    logic [COL_W-1:0] out_column_reg;
    logic [COST_W-1:0] match_cost_reg;
    logic             backward_reg;

    logic ready_out;
    logic ready3;
    logic ready2;
    logic accept;

    // Template memory split by column parity
    pix_t even_mem [BANK_DEPTH];
    pix_t odd_mem  [BANK_DEPTH];

    loc_t             loc_f;
    loc_t             loc_b;
    logic [AW:0]      fl_f_p1;
    logic [AW:0]      fl_b_p1;
    logic [BA_W-1:0]  even_addr_f;
    logic [BA_W-1:0]  odd_addr_f;
    logic [BA_W-1:0]  even_addr_b;
    logic [BA_W-1:0]  odd_addr_b;
    logic [BA_W-1:0]  wr_addr;
    logic             wr_en;
    pix_t             in_pix;

    pix_t             lo_f;
    pix_t             hi_f;
    pix_t             lo_b;
    pix_t             hi_b;
    lane_ctrl_t       lane_ctrl;
    logic [COST_W-1:0] cost_f;
    logic [COST_W-1:0] cost_b;

    // Advance each stage when the one after it has room
    assign ready_out = !o_valid_reg || out_ready;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign in_ready  = !v1_reg || ready2;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign in_pix[0] = red;
    assign in_pix[1] = green;
    assign in_pix[2] = blue;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg       <= RESET_LAST;
            shift_negative_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:    last_col_reg       <= last_column(cfg_data);
                CFG_SHIFT_NEGATIVE: shift_negative_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Read addresses: odd bank at fl/2, even bank at (fl+1)/2
    always_comb
    begin
        loc_f       = locate(column, disp_forward, shift_negative_reg, last_col_reg);
        loc_b       = locate(column, disp_backward, shift_negative_reg, last_col_reg);
        fl_f_p1     = {1'b0, loc_f.fl} + 1'b1;
        fl_b_p1     = {1'b0, loc_b.fl} + 1'b1;
        even_addr_f = BA_W'(fl_f_p1 >> 1);
        even_addr_b = BA_W'(fl_b_p1 >> 1);
        odd_addr_f  = BA_W'(loc_f.fl >> 1);
        odd_addr_b  = BA_W'(loc_b.fl >> 1);
        wr_addr     = BA_W'(column >> 1);
        wr_en       = accept && (cmd == CMD_STORE) && (32'(column) < MAX_WIDTH);
    end

    // Store template pixels; read both neighbors of both hypotheses
    always_ff @(posedge clk)
    begin
        if (wr_en && !column[0])
        begin
            even_mem[wr_addr] <= in_pix;
        end
        if (wr_en && column[0])
        begin
            odd_mem[wr_addr] <= in_pix;
        end
        if (in_ready)
        begin
            even_f_rd_reg <= even_mem[even_addr_f];
            odd_f_rd_reg  <= odd_mem[odd_addr_f];
            even_b_rd_reg <= even_mem[even_addr_b];
            odd_b_rd_reg  <= odd_mem[odd_addr_b];
        end
    end

    // Stage 1 request fields
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            col1_reg   <= column;
            ref1_reg   <= in_pix;
            fr_f1_reg  <= loc_f.fr;
            fr_b1_reg  <= loc_b.fr;
            odd_f1_reg <= loc_f.fl[0];
            odd_b1_reg <= loc_b.fl[0];
        end
    end

    // Only evaluate requests enter the cost pipeline
    assign v1_next = accept && (cmd == CMD_EVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v1_reg <= v1_next;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready_out)
            begin
                o_valid_reg <= v3_reg;
            end
        end
    end

    // Pick floor and upper neighbor by floor parity
    assign lo_f = odd_f1_reg ? odd_f_rd_reg  : even_f_rd_reg;
    assign hi_f = odd_f1_reg ? even_f_rd_reg : odd_f_rd_reg;
    assign lo_b = odd_b1_reg ? odd_b_rd_reg  : even_b_rd_reg;
    assign hi_b = odd_b1_reg ? even_b_rd_reg : odd_b_rd_reg;

    assign lane_ctrl.load_interp = ready2;
    assign lane_ctrl.load_cost   = ready3;

    ddmc_cost_lane u_lane_fwd (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .lo_pix  (lo_f),
        .hi_pix  (hi_f),
        .frac    (fr_f1_reg),
        .ref_pix (ref1_reg),
        .cost    (cost_f)
    );

    ddmc_cost_lane u_lane_bwd (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .lo_pix  (lo_b),
        .hi_pix  (hi_b),
        .frac    (fr_b1_reg),
        .ref_pix (ref1_reg),
        .cost    (cost_b)
    );

    // Carry the column alongside the cost lanes
    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            col2_reg <= col1_reg;
        end
        if (ready3)
        begin
            col3_reg <= col2_reg;
        end
    end

    // Choose the cheaper hypothesis; backward wins ties
    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            out_column_reg <= col3_reg;
            backward_reg   <= (cost_b <= cost_f);
            match_cost_reg <= (cost_b <= cost_f) ? cost_b : cost_f;
        end
    end

    assign out_valid       = o_valid_reg;
    assign out_column      = out_column_reg;
    assign match_cost      = match_cost_reg;
    assign backward_chosen = backward_reg;

`ifndef SYNTHESIS
    // An accepted request enters stage 1 exactly when it is an evaluate
    a_stage1_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (v1_reg == ($past(cmd) == CMD_EVAL)))
        else $error("stage 1 valid does not follow the accepted request");

    // A stalled last stage keeps its result
    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && o_valid_reg && !out_ready) |=> v3_reg)
        else $error("stage 3 result dropped under stall");

    // No request is taken while stage 1 cannot move on
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && o_valid_reg && !out_ready) |-> !in_ready)
        else $error("request accepted into a full pipeline");
`endif

endmodule
